@@ rtl/core/sorted_table_binary_search_unit_defines.svh @@
// Assertion macros for the sorted table binary search unit checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted table check failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define STBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted table check failed (next cycle)");

`endif

@@ rtl/core/stbs_pkg.sv @@
// Package for the sorted table binary search unit: sizes, codes and types.
// Used by the interfaces, the table cell, the top level and the checker.
`timescale 1ns / 1ps

package stbs_pkg;

    // Table size and derived widths.
    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 31;
    localparam int INDEX_W  = 6;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [IDX_W-1:0]   pos_t;

    // Word kinds on the request channel.
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_SEARCH = 1'b1
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_SEARCH,
        S_DONE
    } fsm_t;

    // What one cell hands to its right-hand neighbour.
    typedef struct packed {
        value_t entry;
        logic   gt;
    } link_t;

endpackage

@@ rtl/core/stbs_req_if.sv @@
// Request and response channel interfaces for the sorted table unit.
// Depends on stbs_pkg for the payload types.
`timescale 1ns / 1ps

interface stbs_req_if;
    logic                 valid;
    logic                 ready;
    stbs_pkg::kind_t      kind;
    stbs_pkg::value_t     value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface stbs_rsp_if;
    logic                 valid;
    logic                 ready;
    stbs_pkg::status_t    status;
    stbs_pkg::index_t     index;

    modport source (output valid, output status, output index, input ready);
    modport sink   (input valid, input status, input index, output ready);
endinterface

@@ rtl/core/stbs_cell.sv @@
// One cell of the sorted table: holds one entry and compares it with the key.
// Depends on stbs_pkg; instantiated in a row by the top level.
`timescale 1ns / 1ps

module stbs_cell (
    input  logic             clk,
    input  stbs_pkg::value_t key,
    input  logic             load,
    input  logic             valid,
    input  logic             tail,
    input  stbs_pkg::link_t  left,
    output stbs_pkg::link_t  right,
    output logic             eq
);
    import stbs_pkg::*;

    value_t entry_reg;
    value_t entry_next;
    logic   gt;

    // Compare the stored entry with the current key.
    assign gt          = valid && (entry_reg > key);
    assign eq          = (entry_reg == key);
    assign right.entry = entry_reg;
    assign right.gt    = gt;

    // On an insert, larger entries move one place right and the key drops
    // into the first cell whose entry is larger, or into the free tail cell.
    always_comb
    begin
        entry_next = entry_reg;
        if (load && ((valid && gt) || tail))
        begin
            entry_next = left.gt ? left.entry : key;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ rtl/core/sorted_table_binary_search_unit.sv @@
// Top level of the sorted table unit: a row of table cells and a sequencer.
// Depends on stbs_pkg, stbs_req_if, stbs_rsp_if and stbs_cell.
`timescale 1ns / 1ps

// Usage
// The request channel carries words of kind and value. An insert word puts
// the value into the table in ascending order after any equal entries and
// answers with status inserted and the new entry count, or status full and
// the unchanged count when all CAPACITY cells are taken. A search word runs
// a binary search over the stored entries and answers with status found and
// the probed position, or status not found and index zero.
// Every request word gives exactly one response word.
// Timing: a word is taken when the unit is idle. An insert passes through
// the cell row, where all cells compare and shift at once. A search probes
// the midpoint of the window, one probe per cycle, up to ceil(log2(N+1))
// probes for N stored entries (six for a full table of 32); a miss ends
// when the window is empty. Next the done state moves the result to the
// response register once that register is free, after which the unit
// returns to idle and can take the next word.
// Reset empties the table and the response register. When the receiver
// stalls, the response waits in its register; the next word may be taken,
// but its result waits until the previous one has been delivered.
module sorted_table_binary_search_unit (
    input  logic       clk,
    input  logic       rst_n,
    stbs_req_if.sink   req,
    stbs_rsp_if.source rsp
);
    import stbs_pkg::*;

    fsm_t    state_reg, state_next;
    value_t  key_reg, key_next;
    count_t  count_reg, count_next;
    count_t  lo_reg, lo_next;
    count_t  hi1_reg, hi1_next;
    status_t res_status_reg, res_status_next;
    index_t  res_index_reg, res_index_next;
    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    index_t  out_index_reg, out_index_next;

    logic                load;
    link_t               link_w [CAPACITY];
    logic [CAPACITY-1:0] gt_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CNT_W:0]      mid_sum;
    pos_t                mid;
    logic                full;

    // Row of table cells; each feeds its entry and compare flag to the right.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        link_t left_w;
        if (i == 0)
        begin : g_first
            assign left_w = '{entry: '0, gt: 1'b0};
        end
        else
        begin : g_rest
            assign left_w = link_w[i-1];
        end

        stbs_cell u_cell (
            .clk   (clk),
            .key   (key_reg),
            .load  (load),
            .valid (count_t'(i) < count_reg),
            .tail  (count_t'(i) == count_reg),
            .left  (left_w),
            .right (link_w[i]),
            .eq    (eq_vec[i])
        );

        assign gt_vec[i] = link_w[i].gt;
    end

    // Midpoint of the current search window, rounded down.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi1_reg} - (CNT_W+1)'(1);
    assign mid     = mid_sum[IDX_W:1];
    assign full    = (count_reg == count_t'(CAPACITY));

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.index  = out_index_reg;

    // Sequencer: next state, search window, table count and results.
    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi1_next        = hi1_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        load            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next   = req.value;
                    lo_next    = '0;
                    hi1_next   = count_reg;
                    state_next = (req.kind == KIND_INSERT) ? S_INSERT : S_SEARCH;
                end
            end
            S_INSERT:
            begin
                if (full)
                begin
                    res_status_next = ST_FULL;
                    res_index_next  = index_t'(count_reg);
                end
                else
                begin
                    load            = 1'b1;
                    count_next      = count_reg + count_t'(1);
                    res_status_next = ST_INSERTED;
                    res_index_next  = index_t'(count_next);
                end
                state_next = S_DONE;
            end
            S_SEARCH:
            begin
                if (lo_reg < hi1_reg)
                begin
                    if (eq_vec[mid])
                    begin
                        res_status_next = ST_FOUND;
                        res_index_next  = index_t'(mid);
                        state_next      = S_DONE;
                    end
                    else if (gt_vec[mid])
                    begin
                        hi1_next = count_t'(mid);
                    end
                    else
                    begin
                        lo_next = count_t'(mid) + count_t'(1);
                    end
                end
                else
                begin
                    res_status_next = ST_MISSING;
                    res_index_next  = '0;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi1_reg        <= hi1_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
    end

endmodule

@@ rtl/core/stbs_checker.sv @@
// Port-level checker for the sorted table binary search unit, bound to it.
// Depends on stbs_pkg and sorted_table_binary_search_unit_defines.svh.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_unit_defines.svh"

module stbs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input stbs_pkg::status_t  rsp_status,
    input stbs_pkg::index_t   rsp_index
);
    import stbs_pkg::*;

    // A stalled response word keeps its payload.
    `STBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_index))

    // The unit is busy in the cycle after taking a request word.
    `STBS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // A miss always reports index zero.
    `STBS_ASSERT_NOW(a_miss_index, rsp_valid && (rsp_status == ST_MISSING), rsp_index == '0)

    // A full table reports its capacity as the count.
    `STBS_ASSERT_NOW(a_full_index, rsp_valid && (rsp_status == ST_FULL), rsp_index == index_t'(CAPACITY))

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_index  (rsp.index)
);

@@ test/tb_sorted_table_binary_search_unit.sv @@
// Testbench for sorted_table_binary_search_unit: inserts and binary searches,
// with each response checked against a model of the table kept in this file.
// Depends on stbs_pkg, stbs_req_if, stbs_rsp_if and the unit itself.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_unit;

    import stbs_pkg::*;

    localparam int     RANDOM_WORDS = 600;
    localparam int     HOLD_CYCLES  = 100;
    localparam int     HOLD_AFTER   = 150;
    localparam int     IDLE_LIMIT   = 2000;
    localparam int     DRAIN_CYCLES = 20;
    localparam value_t VALUE_TOP    = 31'h7FFF_FFFF;

    typedef struct {
        kind_t  kind;
        value_t value;
    } req_word_t;

    typedef struct {
        status_t status;
        index_t  index;
    } rsp_word_t;

    logic   clk;
    logic   rst_n     = 1'b0;
    logic   req_valid = 1'b0;
    kind_t  req_kind  = KIND_INSERT;
    value_t req_value = '0;
    logic   rsp_ready = 1'b0;

    // Handshakes seen at the last rising edge, read by the falling-edge drivers.
    logic req_fire;
    logic rsp_fire;

    req_word_t pending_words[$];
    rsp_word_t awaited_results[$];
    value_t    inserted_values[$];

    // Copy of the table as the unit should hold it.
    value_t sorted_copy [CAPACITY];
    int     stored_count = 0;

    int words_sent;
    int results_seen;
    int mismatch_total = 0;
    int idle_cycles    = 0;
    int send_gap;
    int stall_left;
    int hold_left;
    logic hold_done;
    int inserts_taken   = 0;
    int inserts_refused = 0;
    int search_hits     = 0;
    int search_misses   = 0;

    stbs_req_if req_ch ();
    stbs_rsp_if rsp_ch ();

    assign req_ch.valid = req_valid;
    assign req_ch.kind  = req_kind;
    assign req_ch.value = req_value;
    assign rsp_ch.ready = rsp_ready;

    sorted_table_binary_search_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Applies one request word to the table copy and returns the response it should give.
    task automatic apply_to_table(input req_word_t w, output rsp_word_t r);
        int pos;
        int k;
        int lo;
        int hi;
        int mid;
        r.status = ST_MISSING;
        r.index  = '0;
        if (w.kind == KIND_INSERT)
        begin
            if (stored_count >= CAPACITY)
            begin
                r.status = ST_FULL;
                r.index  = index_t'(stored_count);
                inserts_refused++;
            end
            else
            begin
                // New value goes after any equal entries.
                pos = stored_count;
                while (pos > 0 && sorted_copy[pos-1] > w.value)
                    pos--;
                for (k = stored_count; k > pos; k--)
                    sorted_copy[k] = sorted_copy[k-1];
                sorted_copy[pos] = w.value;
                stored_count++;
                r.status = ST_INSERTED;
                r.index  = index_t'(stored_count);
                inserts_taken++;
            end
        end
        else
        begin
            lo = 0;
            hi = stored_count - 1;
            while (lo <= hi && r.status != ST_FOUND)
            begin
                mid = (lo + hi) / 2;
                if (sorted_copy[mid] > w.value)
                    hi = mid - 1;
                else if (sorted_copy[mid] < w.value)
                    lo = mid + 1;
                else
                begin
                    r.status = ST_FOUND;
                    r.index  = index_t'(mid);
                end
            end
            if (r.status == ST_FOUND)
                search_hits++;
            else
                search_misses++;
        end
    endtask

    task automatic queue_word(input kind_t kind, input value_t value);
        req_word_t w;
        w.kind  = kind;
        w.value = value;
        pending_words.push_back(w);
        if (kind == KIND_INSERT)
            inserted_values.push_back(value);
    endtask

    // Sender: presents the next queued word once the previous one is taken.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req_kind   <= KIND_INSERT;
            req_value  <= '0;
            send_gap   <= 0;
            words_sent <= 0;
        end
        else if (!req_valid || req_fire)
        begin
            if (send_gap != 0)
            begin
                req_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (pending_words.size() != 0)
            begin
                req_valid  <= 1'b1;
                req_kind   <= pending_words[0].kind;
                req_value  <= pending_words[0].value;
                pending_words.pop_front();
                words_sent <= words_sent + 1;
                // Every fourth stretch of fifty words goes without gaps.
                send_gap   <= (((words_sent / 50) % 4) == 2) ? 0 : $urandom_range(0, 4);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: stalls at random after words, and once for a long stretch to back the unit up.
    always @(negedge clk or negedge rst_n)
    begin : receiver
        int draw;
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (rsp_fire)
        begin
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                rsp_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else
            begin
                draw = (((results_seen / 50) % 4) == 2) ? 0 : $urandom_range(0, 4);
                rsp_ready <= (draw == 0);
                if (draw != 0)
                    stall_left <= draw - 1;
            end
        end
        else if (stall_left != 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Monitor: predicts each accepted request word and checks each response word.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        req_word_t taken;
        rsp_word_t want;
        if (!rst_n)
        begin
            req_fire     <= 1'b0;
            rsp_fire     <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            rsp_fire <= rsp_ch.valid && rsp_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                taken.kind  = req_ch.kind;
                taken.value = req_ch.value;
                apply_to_table(taken, want);
                awaited_results.push_back(want);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected response word: status %0d, index %0d",
                           rsp_ch.status, rsp_ch.index);
                    mismatch_total++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp_ch.status);
                        mismatch_total++;
                    end
                    if (rsp_ch.index !== want.index)
                    begin
                        $error("index mismatch: expected %0d, actual %0d",
                               want.index, rsp_ch.index);
                        mismatch_total++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout after %0d cycles without a handshake", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int     n;
        kind_t  kind;
        value_t value;

        // Directed part: empty table, extreme values, duplicates and gaps between entries.
        queue_word(KIND_SEARCH, '0);
        queue_word(KIND_SEARCH, VALUE_TOP);
        queue_word(KIND_INSERT, VALUE_TOP);
        queue_word(KIND_INSERT, '0);
        queue_word(KIND_INSERT, '0);
        queue_word(KIND_INSERT, 31'd1000);
        queue_word(KIND_INSERT, 31'd1000);
        queue_word(KIND_INSERT, 31'd1000);
        queue_word(KIND_INSERT, 31'h5555_5555);
        queue_word(KIND_INSERT, 31'h2AAA_AAAA);
        queue_word(KIND_SEARCH, '0);
        queue_word(KIND_SEARCH, VALUE_TOP);
        queue_word(KIND_SEARCH, 31'd1000);
        queue_word(KIND_SEARCH, 31'd999);
        queue_word(KIND_SEARCH, 31'd1001);
        queue_word(KIND_SEARCH, VALUE_TOP - 31'd1);
        queue_word(KIND_SEARCH, 31'h5555_5555);
        queue_word(KIND_SEARCH, 31'h2AAA_AAAA);
        queue_word(KIND_SEARCH, 31'd1);

        // Random part: the table fills over the first couple of hundred words,
        // after which inserts are refused and searches run over a full table.
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            kind = ($urandom_range(0, 4) == 0) ? KIND_INSERT : KIND_SEARCH;
            case ($urandom_range(0, 3))
                0:
                    value = ($urandom_range(0, 1) == 0) ? value_t'($urandom_range(0, 15))
                          : (($urandom_range(0, 1) == 0) ? VALUE_TOP : '0);
                1:
                    value = inserted_values[$urandom_range(0, inserted_values.size() - 1)];
                2:
                begin
                    value = inserted_values[$urandom_range(0, inserted_values.size() - 1)];
                    value = ($urandom_range(0, 1) == 0) ? value + 31'd1 : value - 31'd1;
                end
                default:
                    value = value_t'($urandom);
            endcase
            queue_word(kind, value);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken and answered, then let the unit settle.
        while (pending_words.size() != 0 || req_valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d inserts stored and %0d refused on a full table,",
                 inserts_taken, inserts_refused);
        $display("and %0d searches that hit and %0d that missed.", search_hits, search_misses);
        if (mismatch_total == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/stbs_pkg.sv
rtl/core/stbs_req_if.sv
rtl/core/stbs_cell.sv
rtl/core/sorted_table_binary_search_unit.sv
rtl/core/stbs_checker.sv
test/tb_sorted_table_binary_search_unit.sv
